// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VDI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/vdi_pkg.sv =====
// Types and constants of the vertex dedup indexer.
`timescale 1ns / 1ps
`default_nettype none
package vdi_pkg;

   localparam int KEY_WORDS = 4;
   localparam int EPOCH_W   = 8;

   localparam logic [63:0] HASH_SEED = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] HASH_MUL  = 64'hFF51AFD7ED558CCD;

   localparam logic [1:0] MODE_2D_TEX = 2'd0;
   localparam logic [1:0] MODE_3D_RAW = 2'd1;
   localparam logic [1:0] MODE_3D_TEX = 2'd2;

   typedef logic [KEY_WORDS-1:0][63:0] key_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] norm_x;
      logic [31:0] norm_y;
      logic [31:0] norm_z;
      logic        last_vertex;
   } req_type;

   typedef struct packed {
      logic [11:0] vertex_index;
      logic        is_new;
      logic        overflow;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      HS_IDLE,
      HS_MUL0,
      HS_MUL1,
      HS_MUL2,
      HS_MIX,
      HS_RED0,
      HS_RED1,
      HS_RED2,
      HS_RED3,
      HS_QMUL,
      HS_FIX,
      HS_DONE
   } hash_state_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_KEY_CHK,
      ST_DONE
   } top_state_type;

endpackage
`default_nettype wire

// ===== design/vertex_dedup_indexer.sv =====
// Per word: the hash (start, four multiply-xorshift rounds, reduction modulo the slot count,
// done), then a read and a check of the probed slot, then the load of the result word; each
// occupied slot passed over adds a slot read, a slot check and a key check; a match adds
// a key check. One vertex at a time; a held result stalls input.
// Reset: a clearing pass writes every slot, with no word accepted;
// the same pass runs again after every 255th asset when the epoch mark wraps.
`timescale 1ns / 1ps
`default_nettype none
module vertex_dedup_indexer #(
   parameter int MAX_UNIQUE = 4096,
   parameter int SLOT_COUNT = 8192
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  vdi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output vdi_pkg::rsp_type rsp_data,
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire  [1:0]       csr_wdata
);
   import vdi_pkg::*;

   localparam int IW  = $clog2(MAX_UNIQUE);
   localparam int CW  = $clog2(MAX_UNIQUE + 1);
   localparam int SW  = $clog2(SLOT_COUNT);
   localparam int SEW = EPOCH_W + IW;

   logic [SEW-1:0] slot_mem [SLOT_COUNT];
   key_type        key_mem  [MAX_UNIQUE];

   top_state_type state_ff, state_in;
   logic [1:0]    mode_ff;
   key_type       key_ff, key_in;
   logic          last_ff;
   logic [SW-1:0] probe_ff, nprobe_ff;
   logic          found_ff, empty_ff;
   logic [CW-1:0] count_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   logic [SEW-1:0] slot_q_ff;
   key_type       key_q_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   logic          hash_start, hash_done;
   logic [SW-1:0] hash_slot;
   logic          slot_we, key_we, rsp_load, insert;
   logic [SW-1:0] slot_wa;
   logic [SEW-1:0] slot_wd;
   logic          use_tex, use_3d, slot_live, key_hit, probe_end;
   logic [SW-1:0] probe_next;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign use_tex = (mode_ff != MODE_3D_RAW);
   assign use_3d  = (mode_ff != MODE_2D_TEX);

   always_comb begin
      key_in[0] = {req_data.pos_y, req_data.pos_x};
      key_in[1] = use_tex ? {req_data.tex_v, req_data.tex_u} : 64'b0;
      key_in[2] = use_3d ? {req_data.norm_x, req_data.pos_z} : 64'b0;
      key_in[3] = use_3d ? {req_data.norm_z, req_data.norm_y} : 64'b0;
   end

   assign slot_live  = (slot_q_ff[SEW-1 -: EPOCH_W] == epoch_ff);
   assign key_hit    = (key_q_ff == key_ff);
   assign probe_end  = (nprobe_ff == SW'(SLOT_COUNT - 1));
   assign probe_next = (probe_ff == SW'(SLOT_COUNT - 1)) ? '0 : probe_ff + 1'b1;
   assign insert     = !found_ff && empty_ff && (count_ff < CW'(MAX_UNIQUE));

   vdi_hash #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_ff),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      hash_start = 1'b0;
      slot_we    = 1'b0;
      slot_wa    = probe_ff;
      slot_wd    = '0;
      key_we     = 1'b0;
      rsp_load   = 1'b0;
      rsp_in.vertex_index = '0;
      rsp_in.is_new       = 1'b0;
      rsp_in.overflow     = 1'b0;
      rsp_in.last_result  = last_ff;
      if (found_ff) begin
         rsp_in.vertex_index = 12'(slot_q_ff[IW-1:0]);
      end else if (insert) begin
         rsp_in.vertex_index = 12'(count_ff[IW-1:0]);
         rsp_in.is_new       = 1'b1;
      end else begin
         rsp_in.overflow = 1'b1;
      end
      case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            if (probe_ff == SW'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            hash_start = 1'b1;
            if (hash_done) begin
               state_in = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: state_in = ST_SLOT_CHK;
         ST_SLOT_CHK: begin
            state_in = slot_live ? ST_KEY_CHK : ST_DONE;
         end
         ST_KEY_CHK: begin
            if (key_hit || probe_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SLOT_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               slot_we  = insert;
               slot_wd  = {epoch_ff, count_ff[IW-1:0]};
               key_we   = insert;
               state_in = (last_ff && epoch_ff == '1) ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_q_ff <= slot_mem[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[IW-1:0]] <= key_ff;
      end
      key_q_ff <= key_mem[slot_q_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_3D_TEX;
         count_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               probe_ff <= probe_next;
               epoch_ff <= EPOCH_W'(1);
            end
            ST_HASH: begin
               probe_ff  <= hash_slot;
               nprobe_ff <= '0;
               found_ff  <= 1'b0;
               empty_ff  <= 1'b0;
            end
            ST_SLOT_CHK: begin
               empty_ff <= !slot_live;
            end
            ST_KEY_CHK: begin
               found_ff <= key_hit;
               if (!key_hit) begin
                  probe_ff  <= probe_next;
                  nprobe_ff <= nprobe_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  if (last_ff) begin
                     count_ff <= '0;
                     probe_ff <= '0;
                     epoch_ff <= epoch_ff + 1'b1;
                  end else if (insert) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            default: begin
               probe_ff <= probe_ff;
            end
         endcase
      end
   end

   // hold the accepted word and the loaded result
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff  <= key_in;
         last_ff <= req_data.last_vertex;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/vdi_hash.sv =====
// Multi-cycle key hash: four multiply-xorshift rounds, then reduction modulo the slot count.
`timescale 1ns / 1ps
`default_nettype none
module vdi_hash #(
   parameter int SLOT_COUNT = 8192
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  vdi_pkg::key_type                     key,
   output logic                                 done,
   output logic [$clog2(SLOT_COUNT)-1:0]        slot
);
   import vdi_pkg::*;

   localparam int SW  = $clog2(SLOT_COUNT);
   localparam int ACW = 64 + SW + 1;
   localparam logic [SW:0] SLOTS = (SW+1)'(SLOT_COUNT);
   localparam logic [64:0] RECIP_FULL = (65'd1 << 64) / 65'(SLOT_COUNT);
   localparam logic [63:0] RECIP = RECIP_FULL[63:0];

   hash_state_type state_ff, state_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] p0_ff;
   logic [31:0] x_ff;
   logic [1:0]  round_ff;
   logic [ACW-1:0] acc_ff;
   logic [SW:0] qm_ff;
   logic [SW:0] diff, fixed;
   logic [SW-1:0] rem_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] mix;

   assign a_in = h_ff ^ key[round_ff];
   assign prod = mul_a * mul_b;
   assign mix  = p0_ff + {x_ff, 32'b0};

   // quotient from the top of h times the reciprocal is short by at most one
   assign diff  = h_ff[SW:0] - qm_ff;
   assign fixed = (diff >= SLOTS) ? diff - SLOTS : diff;

   // shared multiplier: hash rounds, then reciprocal partial products, then quotient x slots
   always_comb begin
      case (state_ff)
         HS_MUL0: begin
            mul_a = a_in[31:0];
            mul_b = HASH_MUL[31:0];
         end
         HS_MUL1: begin
            mul_a = a_ff[31:0];
            mul_b = HASH_MUL[63:32];
         end
         HS_MUL2: begin
            mul_a = a_ff[63:32];
            mul_b = HASH_MUL[31:0];
         end
         HS_RED0: begin
            mul_a = h_ff[31:0];
            mul_b = RECIP[31:0];
         end
         HS_RED1: begin
            mul_a = h_ff[31:0];
            mul_b = RECIP[63:32];
         end
         HS_RED2: begin
            mul_a = h_ff[63:32];
            mul_b = RECIP[31:0];
         end
         HS_RED3: begin
            mul_a = h_ff[63:32];
            mul_b = RECIP[63:32];
         end
         HS_QMUL: begin
            mul_a = 32'(acc_ff[ACW-1 -: SW+1]);
            mul_b = 32'(SLOT_COUNT);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      h_in     = mix ^ (mix >> 29);
      done     = 1'b0;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               state_in = HS_MUL0;
            end
         end
         HS_MUL0: state_in = HS_MUL1;
         HS_MUL1: state_in = HS_MUL2;
         HS_MUL2: state_in = HS_MIX;
         HS_MIX: begin
            state_in = (round_ff == 2'(KEY_WORDS - 1)) ? HS_RED0 : HS_MUL0;
         end
         HS_RED0: state_in = HS_RED1;
         HS_RED1: state_in = HS_RED2;
         HS_RED2: state_in = HS_RED3;
         HS_RED3: state_in = HS_QMUL;
         HS_QMUL: state_in = HS_FIX;
         HS_FIX:  state_in = HS_DONE;
         HS_DONE: begin
            done     = 1'b1;
            state_in = HS_IDLE;
         end
         default: state_in = HS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         HS_IDLE: begin
            h_ff     <= HASH_SEED;
            round_ff <= '0;
         end
         HS_MUL0: begin
            a_ff  <= a_in;
            p0_ff <= prod;
         end
         HS_MUL1: x_ff <= prod[31:0];
         HS_MUL2: x_ff <= x_ff + prod[31:0];
         HS_MIX: begin
            h_ff     <= h_in;
            round_ff <= round_ff + 2'd1;
         end
         HS_RED0: acc_ff <= ACW'(prod);
         HS_RED1: acc_ff <= acc_ff + (ACW'(prod) << 32);
         HS_RED2: acc_ff <= acc_ff + (ACW'(prod) << 32);
         HS_RED3: acc_ff <= acc_ff + (ACW'(prod) << 64);
         HS_QMUL: qm_ff <= prod[SW:0];
         HS_FIX:  rem_ff <= fixed[SW-1:0];
         default: begin
            h_ff <= h_ff;
         end
      endcase
   end

   assign slot = rem_ff;

endmodule
`default_nettype wire

// ===== design/vdi_checker.sv =====
// Port-level checker for the vertex dedup indexer, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vdi_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input vdi_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input vdi_pkg::rsp_type rsp_data,
   input wire              csr_valid,
   input wire              csr_ready,
   input wire [1:0]        csr_wdata
);
   import vdi_pkg::*;

   `VDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `VDI_ASSERT_IMPL(a_new_xor_ovf, clock, reset, rsp_valid, !(rsp_data.is_new && rsp_data.overflow))
   `VDI_ASSERT_IMPL(a_ovf_zero, clock, reset, rsp_valid && rsp_data.overflow, rsp_data.vertex_index == 12'd0)
   `VDI_ASSERT_NEXT(a_no_instant, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid)
   `VDI_ASSERT_IMPL(a_clear_after_reset, clock, reset, $fell(reset), !req_ready)

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (.*);
`default_nettype wire
